### src/fgpr_pkg.sv
// Package: constants and types for the framed glyph packet receiver.
`default_nettype none
package fgpr_pkg;
  localparam int unsigned PayloadBytesDefault = 64;
  localparam logic [7:0]  Pre0 = 8'h55;
  localparam logic [7:0]  Pre1 = 8'hAA;
  localparam logic [7:0]  Foot = 8'hFF;
  localparam logic [31:0] ThreshReset = 32'h3F7F3B64;
  localparam logic [0:0]  RegThreshold = 1'b0;
  localparam logic        KindPayload = 1'b0;
  localparam logic        KindVeto = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT0, PH_HUNT1, PH_COH, PH_PAY, PH_FOOT, PH_EMIT, PH_VETO
  } phase_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] b);
    logic [31:0] v;
    v = (b == 32'h8000_0000) ? 32'd0 : b;
    return v[31] ? ~v : (v | 32'h8000_0000);
  endfunction
endpackage
`default_nettype wire

### src/framed_glyph_packet_receiver.sv
// Top level: framed packet receiver with payload buffer memory and APB threshold register.
// Bytes are taken one per cycle while the parser hunts for 0x55 0xAA, collects a
// little-endian float coherence and PAYLOAD_BYTES payload bytes into an on-chip
// buffer, then checks the footer 0xFF. On a good footer with coherence >=
// threshold (float compare, NaN fails) the payload is replayed from the buffer
// memory, one result per cycle as the single read port allows while the output
// does not stall, with last_of_run on the final byte. Input is held off (stall
// high) from the footer until the last result has been taken. A failing compare
// gives one veto result and holds input off until that result has been taken. A
// wrong footer drops the packet. The threshold register (address 0) resets to 0.997.
`default_nettype none
module framed_glyph_packet_receiver
  import fgpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [7:0]       payload_byte,
  output logic [5:0]       payload_index,
  output logic [31:0]      coherence_bits,
  output logic             last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned IdxW = 6;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PAYLOAD_BYTES - 1);

  phase_t phase, phase_next;
  logic [IdxW-1:0] count, count_next;   // byte position within phase
  logic [31:0] coh, coh_next;
  logic [31:0] thresh;
  logic [7:0]  mem [0:63];
  logic [7:0]  rd_data;
  logic [IdxW-1:0] rd_addr;
  logic        rd_pend;                 // read data waiting for the output register
  logic [IdxW-1:0] rd_idx;              // index of data in rd_data
  logic        in_acc, out_acc, pass, issue, load;

  // APB: one register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegThreshold) ? thresh : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= ThreshReset;
    end else if (psel && penable && pwrite && paddr[2] == RegThreshold) begin
      thresh <= pwdata;
    end
  end

  assign pass = !is_nan(coh) && !is_nan(thresh) && (order_key(coh) >= order_key(thresh));
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Read data moves into the output register when that is empty or being taken.
  assign load = rd_pend && (!out_valid || out_acc);
  // Next read goes out when no read data waits, or the waiting data moves now.
  assign issue = (phase == PH_EMIT) && (!rd_pend || load);

  always_comb begin
    phase_next = phase;
    count_next = count;
    coh_next = coh;
    in_stall = (phase == PH_EMIT) || (phase == PH_VETO) || out_valid || rd_pend;
    rd_addr = count;
    unique case (phase)
      PH_HUNT1: if (in_acc) begin
        if (rx_byte == Pre1) begin
          phase_next = PH_COH; count_next = '0; coh_next = '0;
        end else phase_next = PH_HUNT0;
      end
      PH_COH: if (in_acc) begin
        coh_next = coh | (32'(rx_byte) << {count[1:0], 3'b000});
        count_next = count + 1'b1;
        if (count[1:0] == 2'd3) begin
          phase_next = PH_PAY; count_next = '0;
        end
      end
      PH_PAY: if (in_acc) begin
        count_next = count + 1'b1;
        if (count == LastIdx) phase_next = PH_FOOT;
      end
      PH_FOOT: if (in_acc) begin
        count_next = '0;
        if (rx_byte != Foot) phase_next = PH_HUNT0;
        else if (pass) phase_next = PH_EMIT;
        else phase_next = PH_VETO;
      end
      PH_EMIT: if (issue) begin
        count_next = count + 1'b1;
        if (count == LastIdx) phase_next = PH_HUNT0;
      end
      PH_VETO: if (!out_valid) phase_next = PH_HUNT0;
      default: if (in_acc) phase_next = (rx_byte == Pre0) ? PH_HUNT1 : PH_HUNT0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT0; count <= '0; coh <= '0; rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next; count <= count_next; coh <= coh_next;
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (phase == PH_VETO && !out_valid) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register: replayed payload byte or the single veto result
  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= KindPayload; payload_byte <= rd_data;
      payload_index <= rd_idx; coherence_bits <= coh;
      last_of_run <= (rd_idx == LastIdx);
    end else if (phase == PH_VETO && !out_valid) begin
      result_kind <= KindVeto; payload_byte <= '0; payload_index <= '0;
      coherence_bits <= coh; last_of_run <= 1'b1;
    end
  end

  // payload buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (phase == PH_PAY && in_acc) mem[count] <= rx_byte;
    if (issue) begin
      rd_data <= mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end
endmodule
`default_nettype wire

### src/fgpr_checker.sv
// Checker: port-level properties of the framed glyph packet receiver, with bind.
`default_nettype none
module fgpr_checker (
  input wire logic clk, rst, in_valid, in_stall, out_valid, out_stall,
  input wire logic result_kind, last_of_run,
  input wire logic [7:0] payload_byte
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("output dropped");
  a_veto_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> last_of_run && payload_byte == 8'd0)
    else $error("veto fields");
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during run");
endmodule
bind framed_glyph_packet_receiver fgpr_checker u_chk (.*);
`default_nettype wire

### test/framed_glyph_packet_receiver_tb.sv
// Testbench: framed glyph packet receiver, checked against a packet-level predictor.
`default_nettype none
module framed_glyph_packet_receiver_tb;
  import fgpr_pkg::*;

  localparam int unsigned NBytes = PayloadBytesDefault;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [5:0]  index;
    logic [31:0] coh;
    logic        last;
  } glyph_result_t;

  // Predicts packet outcomes and holds the results still owed by the block.
  class packet_scoreboard;
    phase_t          phase;
    logic [6:0]      count;
    logic [31:0]     coh_word;
    logic [31:0]     threshold;
    logic [7:0]      store [NBytes];
    glyph_result_t   pending [$];
    int              mismatches;

    function void clear();
      phase = PH_HUNT0;
      count = '0;
      coh_word = '0;
      threshold = ThreshReset;
      mismatches = 0;
      pending.delete();
    endfunction

    function bit nan_bits(logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    // Sign-magnitude to unsigned order, -0 folded onto +0.
    function logic [31:0] sort_key(logic [31:0] b);
      logic [31:0] v;
      v = (b == 32'h8000_0000) ? 32'd0 : b;
      return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    function void note_byte(logic [7:0] b);
      glyph_result_t r;
      case (phase)
        PH_HUNT1: begin
          if (b == Pre1) begin
            phase = PH_COH;
            count = '0;
            coh_word = '0;
          end else begin
            phase = PH_HUNT0;
          end
        end
        PH_COH: begin
          coh_word = coh_word | (32'(b) << (8 * count[1:0]));
          count = 7'(count + 1);
          if (count >= 4) begin
            phase = PH_PAY;
            count = '0;
          end
        end
        PH_PAY: begin
          store[count[5:0]] = b;
          count = 7'(count + 1);
          if (count >= NBytes) phase = PH_FOOT;
        end
        PH_FOOT: begin
          if (b == Foot) begin
            if (!nan_bits(coh_word) && !nan_bits(threshold) &&
                sort_key(coh_word) >= sort_key(threshold)) begin
              for (int i = 0; i < NBytes; i++) begin
                r.kind = KindPayload;
                r.data = store[i];
                r.index = 6'(i);
                r.coh = coh_word;
                r.last = (i == NBytes - 1);
                pending.push_back(r);
              end
            end else begin
              r = '{KindVeto, 8'd0, 6'd0, coh_word, 1'b1};
              pending.push_back(r);
            end
          end
          phase = PH_HUNT0;
          count = '0;
        end
        default: phase = (b == Pre0) ? PH_HUNT1 : PH_HUNT0;
      endcase
    endfunction

    function void check_result(glyph_result_t got);
      glyph_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: kind %0d/%0d byte %h/%h idx %0d/%0d",
                    " coh %h/%h last %0d/%0d"},
                   want.kind, got.kind, want.data, got.data, want.index, got.index,
                   want.coh, got.coh, want.last, got.last);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [7:0] rx_byte;
  logic out_valid, out_stall;
  logic result_kind, last_of_run;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic [31:0] coherence_bits;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  packet_scoreboard sb;
  int idle_cycles = 0;
  int hold_off;      // long output stall requested by the stimulus
  logic [7:0] tx [$];  // bytes queued for the sender

  framed_glyph_packet_receiver dut (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .result_kind, .payload_byte, .payload_index, .coherence_bits, .last_of_run,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("framed_glyph_packet_receiver verification failed");
        $finish;
      end
    end
  end

  // Result side: random stall per result, plus the long hold-off on request.
  initial begin : result_side
    int wait_n;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) wait_n = 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result('{result_kind, payload_byte, payload_index, coherence_bits,
                        last_of_run});
    end
  end

  // Sends every queued byte, with a random gap before each when gaps is set.
  task automatic send_queued(bit gaps);
    int gap;
    while (tx.size() > 0) begin
      gap = gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= tx[0];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_byte(tx.pop_front());
    end
    in_valid <= 1'b0;
  endtask

  task automatic queue_packet(logic [31:0] coh, bit fixed_pay, logic [7:0] fill,
                              logic [7:0] footer);
    tx.push_back(Pre0);
    tx.push_back(Pre1);
    for (int i = 0; i < 4; i++) tx.push_back(coh[8*i +: 8]);
    for (int i = 0; i < NBytes; i++)
      tx.push_back(fixed_pay ? fill : 8'($urandom_range(0, 255)));
    tx.push_back(footer);
  endtask

  // Waits until every owed result is in, then a settling margin.
  task automatic drain();
    int n;
    n = 0;
    while (sb.pending.size() > 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic apb_write(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegThreshold, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.threshold = value;
  endtask

  initial begin : stimulus
    logic [31:0] coh2;
    sb = new();
    sb.clear();
    hold_off = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hunt: stray byte, then a wrong second byte even though it is 0x55.
    tx.push_back(8'h00);
    tx.push_back(Pre0);
    tx.push_back(Pre0);
    tx.push_back(Pre1);
    // Equal to the reset threshold passes; the next packet vetoes, just below
    // or NaN. The receiver holds off during the first replay while the sender
    // keeps offering the second packet.
    queue_packet(32'h3F7F_3B64, 0, 8'h00, Foot);
    coh2 = $urandom_range(0, 1) ? 32'h3F7F_3B63 : 32'h7FC0_0001;
    queue_packet(coh2, 0, 8'h00, Foot);
    hold_off = 300;
    send_queued(1);
    drain();   // sender pauses until all owed results are in

    // -0 threshold against +0 coherence compares equal and passes, unless
    // the footer is wrong and the packet is dropped.
    apb_write(32'h8000_0000);
    queue_packet(32'h0000_0000, 1, 8'hFF,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254)) : Foot);
    send_queued(1);
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("framed_glyph_packet_receiver verification clean");
    else
      $display("framed_glyph_packet_receiver verification failed");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
src/fgpr_pkg.sv
src/framed_glyph_packet_receiver.sv
src/fgpr_checker.sv
test/framed_glyph_packet_receiver_tb.sv
